// File: src/mrfd_pkg.sv
// ----------------------------------------------------------------------------
// mrfd_pkg
// Shared types, constants and per-kind tables of the reply frame decoder.
// ----------------------------------------------------------------------------
package mrfd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 16;
    localparam int IDX_W  = 4;     // highest frame index decoded is 13
    localparam int KIND_W = 4;
    localparam int PORT_W = 2;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;
    localparam int ADDR_W = 3;     // registers at byte 0 and 4
    localparam int PROD_W = 26;    // 16-bit raw times 10-bit scale
    localparam int SCALE_SHIFT = 12;

    // frame status codes
    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_SUM = 2'd1;
    localparam logic [STAT_W-1:0] ST_LEN = 2'd2;

    // register select (paddr bit 2)
    localparam logic REG_KIND = 1'b0;
    localparam logic REG_PORT = 1'b1;

    // device kinds
    localparam logic [KIND_W-1:0] K_METER_A   = 4'd0;
    localparam logic [KIND_W-1:0] K_METER_NET = 4'd1;
    localparam logic [KIND_W-1:0] K_RECT_NEO  = 4'd2;
    localparam logic [KIND_W-1:0] K_RECT_A    = 4'd3;
    localparam logic [KIND_W-1:0] K_RECT_NET  = 4'd4;
    localparam logic [KIND_W-1:0] K_TH_NEO    = 4'd5;
    localparam logic [KIND_W-1:0] K_TH_A      = 4'd6;
    localparam logic [KIND_W-1:0] K_TH_NET    = 4'd7;
    localparam logic [KIND_W-1:0] K_GEN       = 4'd8;
    localparam logic [KIND_W-1:0] K_RFID      = 4'd9;

    localparam logic [KIND_W-1:0] KIND_RESET = K_METER_A;
    localparam logic [PORT_W-1:0] PORT_RESET = 2'd1;

    localparam logic [7:0]  ASCII_ZERO  = 8'h30;
    localparam logic [7:0]  ASCII_ONE   = 8'h31;
    localparam logic [7:0]  ASCII_TWO   = 8'h32;
    localparam logic [7:0]  ASCII_MINUS = 8'h2D;
    localparam logic [7:0]  GEN_INV     = 8'h01;
    localparam logic [9:0]  SCALE_RECT  = 10'd310;
    localparam logic [9:0]  SCALE_TH    = 10'd1000;
    localparam logic [15:0] TH_TEMP_OFS = 16'hFFEC;   // -20
    localparam logic [15:0] TH_HUM_OFS  = 16'd70;

    typedef enum logic [3:0] {
        A_COPY,
        A_HI,
        A_LO,
        A_SIGN,
        A_DIGIT,
        A_DIG_END,
        A_GEN_INV,
        A_GEN_FLAGS,
        A_GEN_DIG,
        A_SKIP
    } t_act;

    typedef struct packed {
        logic       acc;
        logic [7:0] data;
        logic       last;
    } t_rx_word;

    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] status;
    } t_frame_end;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_rd_req;

    function automatic logic [LEN_W-1:0] expect_len(input logic [KIND_W-1:0] kind);
        logic [LEN_W-1:0] l;
        case (kind)
            K_METER_A:   l = 5'd14;
            K_METER_NET: l = 5'd16;
            K_RECT_NEO:  l = 5'd8;
            K_RECT_A:    l = 5'd7;
            K_RECT_NET:  l = 5'd7;
            K_TH_NEO:    l = 5'd6;
            K_TH_A:      l = 5'd12;
            K_TH_NET:    l = 5'd13;
            K_GEN:       l = 5'd7;
            K_RFID:      l = 5'd12;
            default:     l = 5'd0;
        endcase
        return l;
    endfunction

    function automatic logic has_sum(input logic [KIND_W-1:0] kind);
        return (kind == K_METER_NET) || (kind == K_RECT_A) || (kind == K_RECT_NET) ||
               (kind == K_TH_A) || (kind == K_TH_NET);
    endfunction

    function automatic logic [IDX_W-1:0] first_idx(input logic [KIND_W-1:0] kind);
        logic [IDX_W-1:0] i;
        case (kind)
            K_METER_NET, K_RECT_NET, K_TH_NET, K_RFID: i = 4'd2;
            default:                                   i = 4'd1;
        endcase
        return i;
    endfunction

    function automatic logic [IDX_W-1:0] last_idx(input logic [KIND_W-1:0] kind);
        logic [IDX_W-1:0] i;
        case (kind)
            K_METER_A:   i = 4'd12;
            K_METER_NET: i = 4'd13;
            K_RECT_NEO:  i = 4'd2;
            K_RECT_A:    i = 4'd4;
            K_RECT_NET:  i = 4'd4;
            K_TH_NEO:    i = 4'd4;
            K_TH_A:      i = 4'd9;
            K_TH_NET:    i = 4'd10;
            K_GEN:       i = 4'd5;
            K_RFID:      i = 4'd9;
            default:     i = 4'd1;
        endcase
        return i;
    endfunction

    // what the decoder does with frame byte idx for a given kind
    function automatic t_act step_act(input logic [KIND_W-1:0] kind,
                                      input logic [IDX_W-1:0]  idx);
        t_act a;
        case (kind)
            K_METER_A, K_METER_NET, K_RFID: a = A_COPY;
            K_RECT_NEO:                     a = (idx == 4'd1) ? A_HI : A_LO;
            K_RECT_A, K_RECT_NET:           a = (idx == 4'd4) ? A_DIG_END : A_DIGIT;
            K_TH_NEO:                       a = idx[0] ? A_HI : A_LO;
            K_TH_A: begin
                if (idx == 4'd1)
                    a = A_SIGN;
                else if ((idx == 4'd5) || (idx == 4'd9))
                    a = A_DIG_END;
                else
                    a = A_DIGIT;
            end
            K_TH_NET: begin
                if (idx == 4'd2)
                    a = A_SIGN;
                else if ((idx == 4'd6) || (idx == 4'd10))
                    a = A_DIG_END;
                else
                    a = A_DIGIT;
            end
            K_GEN: begin
                case (idx)
                    4'd2:    a = A_SKIP;
                    4'd3:    a = A_GEN_FLAGS;
                    4'd4:    a = A_GEN_DIG;
                    default: a = A_GEN_INV;
                endcase
            end
            default: a = A_SKIP;
        endcase
        return a;
    endfunction

    // acc*10 + (d - '0'), wrapped to 16 bits
    function automatic logic [15:0] dig_acc(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] t;
        t = (acc << 3) + (acc << 1) + {8'd0, d} - {8'd0, ASCII_ZERO};
        return t;
    endfunction

endpackage

// File: src/mrfd_rx_if.sv
// ----------------------------------------------------------------------------
// mrfd_rx_if
// Received byte channel: one frame byte and a last-byte flag per word.
// ----------------------------------------------------------------------------
interface mrfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

// File: src/mrfd_rec_if.sv
// ----------------------------------------------------------------------------
// mrfd_rec_if
// Record channel: decoded record bytes with status and port tag.
// ----------------------------------------------------------------------------
interface mrfd_rec_if;
    logic       valid;
    logic       ready;
    logic [7:0] record_byte;
    logic       record_last;
    logic [1:0] frame_status;
    logic [1:0] port_tag;

    modport source (output valid, output record_byte, output record_last,
                    output frame_status, output port_tag, input ready);
    modport sink   (input valid, input record_byte, input record_last,
                    input frame_status, input port_tag, output ready);
endinterface

// File: src/mrfd_cfg.sv
// ----------------------------------------------------------------------------
// mrfd_cfg
// APB register file: device kind and port index.
// ----------------------------------------------------------------------------
module mrfd_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrfd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [mrfd_pkg::KIND_W-1:0]  o_kind,
    output logic [mrfd_pkg::PORT_W-1:0]  o_port
);
    import mrfd_pkg::*;

    logic [KIND_W-1:0] r_kind;
    logic [PORT_W-1:0] r_port;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_RESET;
            r_port <= PORT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_KIND: r_kind <= pwdata[KIND_W-1:0];
                REG_PORT: r_port <= pwdata[PORT_W-1:0];
                default: ;
            endcase
        end
    end

    // low address bits are don't-care for the word-aligned map
    always_comb begin
        unique case (paddr[2])
            REG_KIND: prdata = {{(32-KIND_W){1'b0}}, r_kind};
            REG_PORT: prdata = {{(32-PORT_W){1'b0}}, r_port};
            default:  prdata = '0;
        endcase
    end

    assign o_kind = r_kind;
    assign o_port = r_port;

endmodule

// File: src/mrfd_frame_store.sv
// ----------------------------------------------------------------------------
// mrfd_frame_store
// Frame buffer memory with fill count, running XOR and length/checksum check.
// ----------------------------------------------------------------------------
module mrfd_frame_store #(
    parameter int MAX_FRAME_BYTES = mrfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mrfd_pkg::t_rx_word              i_wr,
    input  logic [mrfd_pkg::KIND_W-1:0]     i_kind,
    input  logic                            i_rd_en,
    input  logic [$clog2(MAX_FRAME_BYTES)-1:0] i_rd_addr,
    output logic [7:0]                      o_rd_data,
    output mrfd_pkg::t_frame_end            o_end
);
    import mrfd_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

    logic [7:0]    mem [MAX_FRAME_BYTES];
    logic [CW-1:0] r_count;
    logic [7:0]    r_xor;
    logic          r_ovf;
    logic [7:0]    r_rd_data;

    logic          full;
    logic [CW-1:0] n_count;
    logic          n_ovf;
    logic [7:0]    n_xor;

    assign full    = (r_count == CW'(MAX_FRAME_BYTES));
    assign n_count = full ? r_count : r_count + CW'(1);
    assign n_ovf   = r_ovf || full;
    assign n_xor   = r_xor ^ i_wr.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_xor   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_wr.acc) begin
            if (i_wr.last) begin
                r_count <= '0;
                r_xor   <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_xor   <= n_xor;
                r_ovf   <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.acc && !full)
            mem[r_count[AW-1:0]] <= i_wr.data;
        if (i_rd_en)
            r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

    // With the right length and no overflow, the last byte sits at len-1,
    // so the check compares the full XOR against the byte now arriving.
    always_comb begin
        o_end.done   = i_wr.acc && i_wr.last;
        o_end.status = ST_OK;
        if (n_ovf || (n_count != CW'(expect_len(i_kind))))
            o_end.status = ST_LEN;
        else if (has_sum(i_kind) && (n_xor != i_wr.data))
            o_end.status = ST_SUM;
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FRAME_BYTES))
        else $error("fill count beyond buffer depth");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> full)
        else $error("overflow flag set with buffer not full");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.acc && i_wr.last) |=> (r_count == '0) && (r_xor == '0) && !r_ovf)
        else $error("frame state not cleared after last byte");

endmodule

// File: src/mrfd_decoder.sv
// ----------------------------------------------------------------------------
// mrfd_decoder
// Sequencer that walks the stored frame, decodes fields and emits the record.
// ----------------------------------------------------------------------------
module mrfd_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mrfd_pkg::t_frame_end         i_end,
    input  logic [mrfd_pkg::KIND_W-1:0]  i_kind,
    input  logic [mrfd_pkg::PORT_W-1:0]  i_port,
    input  logic [7:0]                   i_rd_data,
    output mrfd_pkg::t_rd_req            o_rd,
    output logic                         o_idle,
    mrfd_rec_if.source                   o_rec
);
    import mrfd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_PROC,
        S_SCALE,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_idx;
    logic [15:0]       r_acc;
    logic              r_neg;
    logic [7:0]        r_hi;
    logic [PROD_W-1:0] r_prod;
    logic [7:0]        r_eb [3];
    logic [1:0]        r_ecnt;
    logic              r_final;
    logic [STAT_W-1:0] r_status;
    logic              r_started;

    logic              r_ovalid;
    logic [7:0]        r_obyte;
    logic              r_olast;
    logic [STAT_W-1:0] r_ostat;
    logic [PORT_W-1:0] r_otag;

    t_act              act;
    logic              at_last;
    logic              load_out;
    logic [15:0]       dig_v;
    logic [15:0]       dig_out;
    logic [15:0]       scaled;
    logic [15:0]       ofs;
    logic [9:0]        coef;
    logic [7:0]        d_dig;

    assign act      = step_act(i_kind, r_idx);
    assign at_last  = (r_idx == last_idx(i_kind));
    assign load_out = (r_state == S_EMIT) && (!r_ovalid || o_rec.ready);
    assign dig_v    = dig_acc(r_acc, i_rd_data);
    assign dig_out  = r_neg ? (16'd0 - dig_v) : dig_v;
    assign d_dig    = i_rd_data - ASCII_ZERO;
    assign coef     = (i_kind == K_RECT_NEO) ? SCALE_RECT : SCALE_TH;

    always_comb begin
        ofs = 16'd0;
        if (i_kind == K_TH_NEO)
            ofs = (r_idx == 4'd2) ? TH_TEMP_OFS : TH_HUM_OFS;
    end

    assign scaled = {{(16 - (PROD_W - SCALE_SHIFT)){1'b0}}, r_prod[PROD_W-1:SCALE_SHIFT]} + ofs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ecnt   <= 2'd0;
            r_final  <= 1'b0;
            r_neg    <= 1'b0;
            r_acc    <= '0;
            r_idx    <= '0;
            r_status <= ST_OK;
        end else begin
            if (load_out)
                r_ovalid <= 1'b1;
            else if (o_rec.ready)
                r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_end.done) begin
                        r_status <= i_end.status;
                        r_eb[0]  <= 8'd0;
                        r_eb[1]  <= 8'd0;
                        r_idx    <= first_idx(i_kind);
                        r_acc    <= '0;
                        r_neg    <= 1'b0;
                        if (i_end.status != ST_OK) begin
                            r_ecnt  <= 2'd1;
                            r_final <= 1'b1;
                        end else begin
                            r_ecnt  <= 2'd2;  // two zero status bytes lead the record
                            r_final <= 1'b0;
                        end
                        r_state <= S_EMIT;
                    end
                end

                S_RD: r_state <= S_PROC;

                S_PROC: begin
                    r_final <= at_last;
                    case (act)
                        A_COPY: begin
                            r_eb[0] <= i_rd_data;
                            r_ecnt  <= 2'd1;
                            r_state <= S_EMIT;
                        end
                        A_HI: begin
                            r_hi    <= i_rd_data;
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_RD;
                        end
                        A_LO: begin
                            r_prod  <= PROD_W'({r_hi, i_rd_data}) * PROD_W'(coef);
                            r_state <= S_SCALE;
                        end
                        A_SIGN: begin
                            r_neg   <= (i_rd_data == ASCII_MINUS);
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_RD;
                        end
                        A_DIGIT: begin
                            r_acc   <= dig_v;
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_RD;
                        end
                        A_DIG_END: begin
                            r_eb[0] <= dig_out[15:8];
                            r_eb[1] <= dig_out[7:0];
                            r_ecnt  <= 2'd2;
                            r_acc   <= '0;
                            r_neg   <= 1'b0;
                            r_state <= S_EMIT;
                        end
                        A_GEN_INV: begin
                            r_eb[0] <= d_dig ^ GEN_INV;
                            r_ecnt  <= 2'd1;
                            r_state <= S_EMIT;
                        end
                        A_GEN_FLAGS: begin
                            r_eb[0] <= {7'd0, i_rd_data == ASCII_ZERO};
                            r_eb[1] <= {7'd0, i_rd_data == ASCII_TWO};
                            r_eb[2] <= {7'd0, i_rd_data == ASCII_ONE};
                            r_ecnt  <= 2'd3;
                            r_state <= S_EMIT;
                        end
                        A_GEN_DIG: begin
                            r_eb[0] <= d_dig;
                            r_ecnt  <= 2'd1;
                            r_state <= S_EMIT;
                        end
                        default: begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= at_last ? S_IDLE : S_RD;
                        end
                    endcase
                end

                S_SCALE: begin
                    r_eb[0] <= scaled[15:8];
                    r_eb[1] <= scaled[7:0];
                    r_ecnt  <= 2'd2;
                    r_state <= S_EMIT;
                end

                S_EMIT: begin
                    if (load_out) begin
                        r_obyte  <= r_eb[0];
                        r_olast  <= (r_ecnt == 2'd1) && r_final;
                        r_ostat  <= r_status;
                        r_otag   <= i_port;
                        r_eb[0]  <= r_eb[1];
                        r_eb[1]  <= r_eb[2];
                        r_ecnt   <= r_ecnt - 2'd1;
                        if (r_ecnt == 2'd1) begin
                            if (r_final) begin
                                r_state <= S_IDLE;
                            end else begin
                                // after a decoded step the walk moves to the next frame byte
                                if (r_started)
                                    r_idx <= r_idx + IDX_W'(1);
                                r_state <= S_RD;
                            end
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // the leading status bytes do not consume a frame byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_started <= 1'b0;
        else if (r_state == S_IDLE)
            r_started <= 1'b0;
        else if (r_state == S_PROC)
            r_started <= 1'b1;
    end

    assign o_rd.en  = (r_state == S_RD);
    assign o_rd.idx = r_idx;
    assign o_idle   = (r_state == S_IDLE);

    assign o_rec.valid        = r_ovalid;
    assign o_rec.record_byte  = r_obyte;
    assign o_rec.record_last  = r_olast;
    assign o_rec.frame_status = r_ostat;
    assign o_rec.port_tag     = r_otag;

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ostat != ST_OK)) |-> ((r_obyte == 8'd0) && r_olast))
        else $error("error word must be a single zero byte");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_end.done |=> (r_state == S_EMIT))
        else $error("frame end did not start a record run");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_end.done |-> (r_state == S_IDLE))
        else $error("frame ended while a run was still in progress");

endmodule

// File: src/module_reply_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// module_reply_frame_decoder_unit
// Decodes a module's serial reply frame into a port record byte run.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        words
//  i_rx     in   valid/ready      rx_byte, last_byte
//  o_rec    out  valid/ready      record_byte, record_last, frame_status, port_tag
//  apb      in   psel/penable     device_kind @0x0, port_index @0x4
//
//  A byte that is not the last of its frame does not start the sequencer.
//  At frame end the sequencer walks the frame buffer through its single read
//  port: each status word is loaded straight to the output, each copied byte
//  is read, decoded and then loaded to the output, and each sign or digit
//  byte is read and decoded.
//  Reset: synchronous, active low; the frame buffer itself is not cleared.
//  o_rec stalls hold the output word; i_rx is taken whenever the sequencer
//  is idle, also while the last word of a run waits.
// ----------------------------------------------------------------------------
module module_reply_frame_decoder_unit #(
    parameter int MAX_FRAME_BYTES = mrfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mrfd_rx_if.sink                      i_rx,
    mrfd_rec_if.source                   o_rec,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrfd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import mrfd_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] port;
    t_rx_word          wr;
    t_frame_end        fend;
    t_rd_req           rd;
    logic [7:0]        rd_data;
    logic              idle;

    assign i_rx.ready = idle;
    assign wr.acc     = i_rx.valid && idle;
    assign wr.data    = i_rx.rx_byte;
    assign wr.last    = i_rx.last_byte;

    mrfd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_kind  (kind),
        .o_port  (port)
    );

    mrfd_frame_store #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_kind    (kind),
        .i_rd_en   (rd.en),
        .i_rd_addr (AW'(rd.idx)),
        .o_rd_data (rd_data),
        .o_end     (fend)
    );

    mrfd_decoder u_dec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_end     (fend),
        .i_kind    (kind),
        .i_port    (port),
        .i_rd_data (rd_data),
        .o_rd      (rd),
        .o_idle    (idle),
        .o_rec     (o_rec)
    );

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reply frame decoder. Frames for every device
// kind go in byte by byte with random gaps and output stalls. A scoreboard
// decodes each finished frame on its own and checks every record word in
// order. Device kind and port are changed over APB between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrfd_pkg::*;

    localparam int              MAX_BYTES  = MAX_FRAME_BYTES_DEF;
    localparam int              N_ITEMS    = 360;
    localparam int              SETTLE     = 60;
    localparam logic [KIND_W-1:0] K_UNKNOWN = 4'd15;
    localparam logic [7:0]      ASCII_PLUS = 8'h2B;

    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        logic [STAT_W-1:0] status;
        logic [PORT_W-1:0] tag;
    } t_rec_word;

    // ------------------------------------------------------------------------
    // frame decoder model and record word checker
    // ------------------------------------------------------------------------
    class frame_record_board;
        logic [7:0]        fbytes [MAX_BYTES];
        int                count;
        logic [7:0]        xsum;
        bit                ovf;
        logic [KIND_W-1:0] kind;
        logic [PORT_W-1:0] port;
        logic [7:0]        run [$];
        t_rec_word         due [$];
        int                failures;
        int                words_seen;
        int                errors_seen;
        int                frames_seen;

        function new();
            count       = 0;
            xsum        = 8'h00;
            ovf         = 1'b0;
            kind        = K_METER_A;
            port        = 2'd1;
            failures    = 0;
            words_seen  = 0;
            errors_seen = 0;
            frames_seen = 0;
        endfunction

        function int frame_len(logic [KIND_W-1:0] k);
            case (k)
                K_METER_A:   return 14;
                K_METER_NET: return 16;
                K_RECT_NEO:  return 8;
                K_RECT_A:    return 7;
                K_RECT_NET:  return 7;
                K_TH_NEO:    return 6;
                K_TH_A:      return 12;
                K_TH_NET:    return 13;
                K_GEN:       return 7;
                K_RFID:      return 12;
                default:     return 0;
            endcase
        endfunction

        function bit sum_checked(logic [KIND_W-1:0] k);
            case (k)
                K_METER_NET, K_RECT_A, K_RECT_NET, K_TH_A, K_TH_NET: return 1'b1;
                default:                                             return 1'b0;
            endcase
        endfunction

        function void put16(logic [15:0] v);
            run.push_back(v[15:8]);
            run.push_back(v[7:0]);
        endfunction

        function logic [31:0] raw(int i);
            return {16'd0, fbytes[i], fbytes[i+1]};
        endfunction

        // any byte counts as a digit; the sum wraps at 16 bits
        function logic [15:0] digits(int i, int cnt);
            logic [15:0] v;
            int k;
            v = 16'd0;
            for (k = 0; k < cnt; k++)
                v = v * 16'd10 + {8'd0, fbytes[i+k]} - {8'd0, ASCII_ZERO};
            return v;
        endfunction

        function void note_rx(logic [7:0] rx, logic fin);
            logic [STAT_W-1:0] st;
            logic [31:0]       w;
            logic [15:0]       v;
            int                len;
            int                o;
            int                k;
            if (count < MAX_BYTES) begin
                fbytes[count] = rx;
                count++;
            end else begin
                ovf = 1'b1;
            end
            xsum ^= rx;
            if (!fin)
                return;

            len = count;
            st  = ST_OK;
            // unknown kinds expect zero bytes, so they always fail on length
            if (ovf || len != frame_len(kind))
                st = ST_LEN;
            else if (sum_checked(kind) && xsum != fbytes[len-1])
                st = ST_SUM;   // total XOR vs last byte == XOR of body vs sum byte
            count = 0;
            xsum  = 8'h00;
            ovf   = 1'b0;
            frames_seen++;
            if (st != ST_OK) begin
                due.push_back(t_rec_word'{8'h00, 1'b1, st, port});
                return;
            end

            run.delete();
            run.push_back(8'h00);
            run.push_back(8'h00);
            case (kind)
                K_METER_A:   for (k = 1; k <= 12; k++) run.push_back(fbytes[k]);
                K_METER_NET: for (k = 2; k <= 13; k++) run.push_back(fbytes[k]);
                K_RFID:      for (k = 2; k <= 9; k++)  run.push_back(fbytes[k]);
                K_RECT_NEO: begin
                    w = raw(1) * 310 / 4096;
                    put16(w[15:0]);
                end
                K_RECT_A:   put16(digits(1, 4));
                K_RECT_NET: put16(digits(2, 3));
                K_TH_NEO: begin
                    w = raw(1) * 1000 / 4096 - 20;
                    put16(w[15:0]);
                    w = raw(3) * 1000 / 4096 + 70;
                    put16(w[15:0]);
                end
                K_TH_A, K_TH_NET: begin
                    o = (kind == K_TH_A) ? 1 : 2;
                    v = digits(o + 1, 4);
                    if (fbytes[o] == ASCII_MINUS)
                        v = 16'd0 - v;
                    put16(v);
                    put16(digits(o + 5, 4));
                end
                K_GEN: begin
                    run.push_back((fbytes[1] - ASCII_ZERO) ^ GEN_INV);
                    run.push_back({7'd0, fbytes[3] == ASCII_ZERO});
                    run.push_back({7'd0, fbytes[3] == ASCII_TWO});
                    run.push_back({7'd0, fbytes[3] == ASCII_ONE});
                    run.push_back(fbytes[4] - ASCII_ZERO);
                    run.push_back((fbytes[5] - ASCII_ZERO) ^ GEN_INV);
                end
                default: ;
            endcase
            for (k = 0; k < run.size(); k++)
                due.push_back(t_rec_word'{run[k], k == run.size() - 1, ST_OK, port});
        endfunction

        function void check_word(t_rec_word got);
            t_rec_word want;
            words_seen++;
            if (got.status != ST_OK)
                errors_seen++;
            if (due.size() == 0) begin
                $display("%0t: unexpected record word: byte %02h last %0d status %0d tag %0d",
                         $time, got.data, got.last, got.status, got.tag);
                failures++;
                return;
            end
            want = due.pop_front();
            if (got !== want) begin
                $display("%0t: record word mismatch: expected byte %02h last %0d status %0d tag %0d",
                         $time, want.data, want.last, want.status, want.tag);
                $display("%0t:                       actual   byte %02h last %0d status %0d tag %0d",
                         $time, got.data, got.last, got.status, got.tag);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, block
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    mrfd_rx_if  rx_ch ();
    mrfd_rec_if rec_ch ();

    frame_record_board board;
    logic [7:0]        frame_q [$];
    bit                quiet;
    int                n_sent;
    int                cfg_writes;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    module_reply_frame_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_rec   (rec_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        #400_000;
        $display("FAIL");
        $finish;
    end

    // record side: random stalls, check every accepted word
    initial begin
        rec_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1)
                board.check_word(t_rec_word'{rec_ch.record_byte, rec_ch.record_last,
                                             rec_ch.frame_status, rec_ch.port_tag});
            rec_ch.ready <= quiet || ($urandom_range(0, 99) >= 14);
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic fin);
        if (!quiet && $urandom_range(0, 99) < 14) begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        rx_ch.valid     <= 1'b1;
        rx_ch.rx_byte   <= b;
        rx_ch.last_byte <= fin;
        do @(posedge i_clk); while (rx_ch.ready !== 1'b1);
        board.note_rx(b, fin);
        n_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_word(frame_q[i], i == frame_q.size() - 1);
    endtask

    // hold the input until every pending record word is out, then let the
    // sequencer settle
    task automatic drain();
        rx_ch.valid <= 1'b0;
        while (board.due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic ra, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ra, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (ra == REG_KIND)
            board.kind = val[KIND_W-1:0];
        else
            board.port = val[PORT_W-1:0];
        cfg_writes++;
    endtask

    task automatic set_config(input logic [KIND_W-1:0] k, input logic [PORT_W-1:0] p);
        drain();
        reg_write(REG_KIND, {28'd0, k});
        reg_write(REG_PORT, {30'd0, p});
    endtask

    // ------------------------------------------------------------------------
    // frame builders
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_digit();
        if ($urandom_range(0, 9) < 9)
            return ASCII_ZERO + 8'($urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] fill_byte(input logic [KIND_W-1:0] k, input int i);
        if (i == 0)
            return 8'($urandom);
        case (k)
            K_RECT_A, K_RECT_NET, K_TH_A, K_TH_NET: return pick_digit();
            K_GEN: return (i == 3) ? ASCII_ZERO + 8'($urandom_range(0, 3)) : pick_digit();
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void seal(input logic [KIND_W-1:0] k);
        logic [7:0] x;
        int         i;
        x = 8'h00;
        if (!board.sum_checked(k) || frame_q.size() < 2)
            return;
        for (i = 0; i < frame_q.size() - 2; i++)
            x ^= frame_q[i];
        frame_q[frame_q.size() - 2] = x;
    endfunction

    function automatic void make_frame(input logic [KIND_W-1:0] k, input int len);
        int i;
        frame_q.delete();
        for (i = 0; i < len; i++)
            frame_q.push_back(fill_byte(k, i));
        if (len > 2 && (k == K_TH_A || k == K_TH_NET)) begin
            case ($urandom_range(0, 2))
                0:       frame_q[k == K_TH_A ? 1 : 2] = ASCII_MINUS;
                1:       frame_q[k == K_TH_A ? 1 : 2] = ASCII_PLUS;
                default: ;
            endcase
        end
        seal(k);
    endfunction

    function automatic void make_good(input logic [KIND_W-1:0] k);
        make_frame(k, board.frame_len(k));
    endfunction

    function automatic void set_four(input logic [7:0] b);
        int i;
        for (i = 1; i <= 4; i++)
            frame_q[i] = b;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [KIND_W-1:0] k;
        int                phase;
        int                phase_end;
        int                len;
        int                shape;

        board      = new();
        quiet      = 1'b0;
        n_sent     = 0;
        cfg_writes = 0;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        rx_ch.valid     <= 1'b0;
        rx_ch.rx_byte   <= 8'h00;
        rx_ch.last_byte <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config first (meter A on port 1)
        make_good(K_METER_A);
        frame_q[1] = 8'hFF;
        frame_q[2] = 8'h00;
        send_frame();

        set_config(K_METER_NET, 2'd3);
        make_good(K_METER_NET);                 // exactly fills the buffer
        send_frame();
        make_good(K_METER_NET);
        frame_q.push_back(8'hA5);               // one byte past the buffer
        send_frame();
        make_good(K_METER_NET);
        frame_q[14] ^= 8'h80;                   // bad checksum
        send_frame();

        set_config(K_RECT_NEO, 2'd0);
        make_good(K_RECT_NEO);
        frame_q[1] = 8'hFF;
        frame_q[2] = 8'hFF;
        send_frame();

        set_config(K_RECT_A, 2'd2);
        make_good(K_RECT_A);
        set_four(8'h39);
        seal(K_RECT_A);
        send_frame();
        make_good(K_RECT_A);
        frame_q[2] = 8'hFF;                     // non-digit in a number
        seal(K_RECT_A);
        send_frame();

        set_config(K_RECT_NET, 2'd1);
        make_good(K_RECT_NET);
        send_frame();

        set_config(K_TH_NEO, 2'd3);
        make_good(K_TH_NEO);
        set_four(8'h00);                        // temperature wraps below zero
        send_frame();
        make_good(K_TH_NEO);
        set_four(8'hFF);
        send_frame();

        set_config(K_TH_A, 2'd1);
        make_good(K_TH_A);
        frame_q[1] = ASCII_MINUS;
        seal(K_TH_A);
        send_frame();
        make_good(K_TH_A);
        frame_q[1] = ASCII_PLUS;
        seal(K_TH_A);
        send_frame();

        set_config(K_TH_NET, 2'd2);
        make_good(K_TH_NET);
        frame_q[2] = ASCII_MINUS;
        seal(K_TH_NET);
        send_frame();

        set_config(K_GEN, 2'd1);
        make_good(K_GEN);
        frame_q[3] = ASCII_ZERO;
        send_frame();
        make_good(K_GEN);
        frame_q[3] = ASCII_ONE;
        send_frame();
        make_good(K_GEN);
        frame_q[3] = ASCII_TWO;
        send_frame();
        make_good(K_GEN);
        frame_q[3] = 8'h37;                     // no flag set
        send_frame();

        set_config(K_RFID, 2'd3);
        make_good(K_RFID);
        send_frame();
        frame_q = '{8'h42};                     // single-byte frame
        send_frame();

        set_config(K_UNKNOWN, 2'd0);
        make_good(K_METER_A);
        send_frame();

        // random phases: one config per phase, mostly well-formed frames
        phase = 0;
        while (n_sent < N_ITEMS) begin
            if ($urandom_range(0, 19) < 18)
                k = KIND_W'($urandom_range(K_METER_A, K_RFID));
            else
                k = KIND_W'($urandom_range(K_RFID + 1, K_UNKNOWN));
            set_config(k, PORT_W'($urandom_range(0, 3)));
            quiet     = (phase == 0) || ($urandom_range(0, 5) == 0);
            phase_end = n_sent + int'($urandom_range(30, 70));
            if (phase_end > N_ITEMS)
                phase_end = N_ITEMS;
            while (n_sent < phase_end) begin
                shape = $urandom_range(0, 99);
                if (k > K_RFID || shape >= 90) begin
                    frame_q.delete();
                    repeat ($urandom_range(1, 18)) frame_q.push_back(8'($urandom));
                end else if (shape >= 82) begin
                    do len = $urandom_range(1, 20); while (len == board.frame_len(k));
                    make_frame(k, len);
                end else begin
                    make_good(k);
                    if (shape >= 74 && board.sum_checked(k))
                        frame_q[frame_q.size() - 2] ^= 8'($urandom_range(1, 255));
                end
                send_frame();
                if ($urandom_range(0, 24) == 0)
                    drain();
            end
            quiet = 1'b0;
            phase++;
        end

        drain();
        $display("covered %0d frames (%0d bytes) across %0d register writes, all kinds and ports",
                 board.frames_seen, n_sent, cfg_writes);
        $display("checked %0d record words, %0d error results, %0d failures",
                 board.words_seen, board.errors_seen, board.failures);
        if (board.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/mrfd_pkg.sv
src/mrfd_rx_if.sv
src/mrfd_rec_if.sv
src/mrfd_cfg.sv
src/mrfd_frame_store.sv
src/mrfd_decoder.sv
src/module_reply_frame_decoder_unit.sv
verif/tb_top.sv
